// ===== rtl/bce_pkg.sv =====
// shared constants for the binary cross entropy loss core
// used by bce_neg_ln and binary_cross_entropy_loss_core; no dependencies
package bce_pkg;

    localparam int FRAC_BITS = 16;
    localparam int IN_W      = FRAC_BITS + 1;
    localparam int LOSS_W    = FRAC_BITS + 7;
    localparam int LOG_FB    = 30;
    localparam int M_W       = LOG_FB + 1;
    localparam int E_W       = 6;
    localparam int L_W       = LOG_FB + E_W;
    localparam int LN2_W     = 28;
    localparam int PL_W      = L_W / 2;
    localparam int PH_W      = L_W - PL_W;
    localparam int RND_SH    = LOG_FB + LN2_W - FRAC_BITS;

    localparam logic [LN2_W-1:0]  LN2_Q28 = LN2_W'(186065279);
    localparam logic [IN_W-1:0]   ONE_FX  = IN_W'(1) << FRAC_BITS;
    localparam logic [LOSS_W-1:0] CLIP_FX = LOSS_W'(100) << FRAC_BITS;

    // stages inside the log unit: normalize, squarings, subtract, multiply, round
    localparam int LN_LAT = LOG_FB + 4;

endpackage

// ===== rtl/bce_neg_ln.sv =====
// pipelined min(-ln(x / 2^F), 100) by normalization and repeated squaring
// depends on bce_pkg; advances when i_en is high
module bce_neg_ln import bce_pkg::*; (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [IN_W-1:0]   i_x,
    output logic [LOSS_W-1:0] o_y
);

    logic [M_W-1:0]    r_m  [0:LOG_FB];
    logic [LOG_FB-1:0] r_fr [0:LOG_FB];
    logic [E_W-1:0]    r_e  [0:LOG_FB];
    logic              r_z  [0:LOG_FB];
    logic [M_W-1:0]    n_m  [1:LOG_FB];
    logic              n_b  [1:LOG_FB];
    logic [E_W-1:0]    n_e0;
    logic [L_W-1:0]    r_l;
    logic              r_lz;
    logic [PL_W+LN2_W-1:0] r_pl;
    logic [PH_W+LN2_W-1:0] r_ph;
    logic              r_pz;
    logic [L_W+LN2_W:0] n_prod;
    logic [L_W+LN2_W-RND_SH:0] n_res;
    logic [LOSS_W-1:0] r_y;

    // leading one position
    always_comb begin
        n_e0 = '0;
        for (int i = 0; i < IN_W; i++) begin
            if (i_x[i]) n_e0 = E_W'(i);
        end
    end

    // one squaring per stage: m = m*m >> 30, renormalize and emit one bit
    always_comb begin
        for (int k = 1; k <= LOG_FB; k++) begin
            logic [2*M_W-1:0] sq;
            sq = r_m[k-1] * r_m[k-1];
            n_b[k] = sq[2*LOG_FB+1];
            n_m[k] = n_b[k] ? sq[2*LOG_FB+1:LOG_FB+1] : sq[2*LOG_FB:LOG_FB];
        end
    end

    assign n_prod = (L_W+LN2_W+1)'(r_pl) + ((L_W+LN2_W+1)'(r_ph) << PL_W)
                  + ((L_W+LN2_W+1)'(1) << (RND_SH - 1));
    assign n_res  = n_prod[L_W+LN2_W:RND_SH];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m[0]  <= M_W'(i_x) << (E_W'(LOG_FB) - n_e0);
            r_fr[0] <= '0;
            r_e[0]  <= n_e0;
            r_z[0]  <= (i_x == '0);
            for (int k = 1; k <= LOG_FB; k++) begin
                r_m[k]  <= n_m[k];
                r_fr[k] <= {r_fr[k-1][LOG_FB-2:0], n_b[k]};
                r_e[k]  <= r_e[k-1];
                r_z[k]  <= r_z[k-1];
            end
            r_l  <= ((L_W'(FRAC_BITS) - L_W'(r_e[LOG_FB])) << LOG_FB)
                  - L_W'(r_fr[LOG_FB]);
            r_lz <= r_z[LOG_FB];
            // product split in two partial products
            r_pl <= r_l[PL_W-1:0] * LN2_Q28;
            r_ph <= r_l[L_W-1:PL_W] * LN2_Q28;
            r_pz <= r_lz;
            if (r_pz || n_res > (L_W+LN2_W-RND_SH+1)'(CLIP_FX)) begin
                r_y <= CLIP_FX;
            end else begin
                r_y <= LOSS_W'(n_res);
            end
        end
    end

    assign o_y = r_y;

endmodule

// ===== rtl/binary_cross_entropy_loss_core.sv =====
// stages: input stage, 34-stage log unit with 30 squaring stages, weighting
// multiply, rounding/output stage
// throughput: one transaction per cycle; the whole pipeline holds when the
// output is stalled. reset clears the valid bits only
// depends on bce_pkg and bce_neg_ln
module binary_cross_entropy_loss_core import bce_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [IN_W-1:0]   i_pred,
    input  logic [IN_W-1:0]   i_label,
    input  logic              i_last,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [LOSS_W-1:0] o_loss,
    output logic              o_last_out
);

    localparam int DEPTH = LN_LAT + 1;

    logic              w_en;
    logic [IN_W-1:0]   r_p, r_q;
    logic [IN_W-1:0]   r_yd [0:DEPTH-1];
    logic              r_ld [0:DEPTH-1];
    logic              r_v  [0:DEPTH-1];
    logic [LOSS_W-1:0] w_tp, w_tq;
    logic [IN_W+LOSS_W-1:0] r_a, r_b;
    logic              r_v2, r_l2;
    logic [IN_W+LOSS_W:0] n_sum;
    logic [IN_W+LOSS_W-FRAC_BITS:0] n_rnd;
    logic [LOSS_W-1:0] r_loss;
    logic              r_vo, r_lo;
    logic [IN_W-1:0]   n_p;

    assign w_en    = !r_vo || i_ready;
    assign o_ready = w_en;
    assign n_p     = (i_pred > ONE_FX) ? ONE_FX : i_pred;

    bce_neg_ln u_ln_p (.i_clk(i_clk), .i_en(w_en), .i_x(r_p), .o_y(w_tp));
    bce_neg_ln u_ln_q (.i_clk(i_clk), .i_en(w_en), .i_x(r_q), .o_y(w_tq));

    assign n_sum = (IN_W+LOSS_W+1)'(r_a) + (IN_W+LOSS_W+1)'(r_b)
                 + ((IN_W+LOSS_W+1)'(1) << (FRAC_BITS - 1));
    assign n_rnd = n_sum[IN_W+LOSS_W:FRAC_BITS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DEPTH; k++) r_v[k] <= 1'b0;
            r_v2 <= 1'b0;
            r_vo <= 1'b0;
        end else if (w_en) begin
            r_v[0] <= i_valid;
            for (int k = 1; k < DEPTH; k++) r_v[k] <= r_v[k-1];
            r_v2 <= r_v[DEPTH-1];
            r_vo <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p     <= n_p;
            r_q     <= ONE_FX - n_p;
            r_yd[0] <= (i_label > ONE_FX) ? ONE_FX : i_label;
            r_ld[0] <= i_last;
            for (int k = 1; k < DEPTH; k++) begin
                r_yd[k] <= r_yd[k-1];
                r_ld[k] <= r_ld[k-1];
            end
            r_a    <= r_yd[DEPTH-1] * w_tp;
            r_b    <= (ONE_FX - r_yd[DEPTH-1]) * w_tq;
            r_l2   <= r_ld[DEPTH-1];
            r_loss <= (n_rnd > (IN_W+LOSS_W-FRAC_BITS+1)'(CLIP_FX)) ? CLIP_FX
                                                                   : LOSS_W'(n_rnd);
            r_lo   <= r_l2;
        end
    end

    assign o_valid    = r_vo;
    assign o_loss     = r_loss;
    assign o_last_out = r_lo;

    a_loss_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vo |-> r_loss <= CLIP_FX)
        else $error("loss above clip value");

    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> r_v[0])
        else $error("accepted transaction not tracked");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> ($stable(r_v2) && $stable(r_v[DEPTH-1]) && $stable(r_v[0])))
        else $error("pipeline moved during stall");

endmodule
